### rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define TCW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("text console writer assertion failed");

// Clocked assertion that is also checked while reset is held.
`define TCW_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("text console writer assertion failed");

`endif

### rtl/core/tcw_pkg.sv
// Shared constants and types of the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int SCREEN_ROWS = 25;
    localparam int SCREEN_COLS = 80;
    localparam int CELL_COUNT  = SCREEN_ROWS * SCREEN_COLS;
    localparam int ADDR_W      = $clog2(CELL_COUNT);
    localparam int IDX_W       = $clog2(CELL_COUNT + 1);

    localparam int OPCODE_W    = 2;
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int IN_ADDR_W   = 11;
    localparam int CELL_W      = 16;
    localparam int ROW_W       = 5;
    localparam int COL_W       = 7;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_USED_W  = CELL_W + ROW_W + COL_W + 1;

    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;

    localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0]  opcode;
        logic [CHAR_W-1:0]    char_code;
        logic [IN_ADDR_W-1:0] cell_address;
    } t_request;

    typedef struct packed {
        logic              did_scroll;
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
        logic [CELL_W-1:0] cell_value;
    } t_result;

endpackage

### rtl/core/text_console_writer.sv
// Top level of the text console writer: stream ports and the output register.
//
// Channel   Direction  Contents
// s         in         request: opcode in tuser; char_code, cell_address in tdata
// m         out        result: cell_value, cursor_row, cursor_column, did_scroll
// cfg       in         char_attribute write, no handshake
//
// One request is in flight at a time: a read waits in the S_READ state for the
// registered screen memory read, and the core result slot must empty first.
// A clear and a put that scrolls both walk all 2000 cells.
// After reset a pass fills the memory with blanks before the first request is
// taken; configuration writes are taken throughout.
// A stalled result port holds one result in the output register and one in the core.
`timescale 1ns / 1ps

module text_console_writer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // opcode[1:0]
    input  logic [tcw_pkg::OPCODE_W-1:0]    i_s_tuser,
    // char_code[7:0], cell_address[18:8], zero padding
    input  logic [tcw_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // cell_value[15:0], cursor_row[20:16], cursor_column[27:21],
    // did_scroll[28], zero padding
    output logic [tcw_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input  logic                            i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]      i_cfg_wdata
);

    tcw_pkg::t_request               req;
    tcw_pkg::t_result                res;
    logic                            res_valid;
    logic                            res_take;
    logic                            r_m_valid;
    logic [tcw_pkg::OUT_TDATA_W-1:0] r_m_data;

    assign req.opcode       = i_s_tuser;
    assign req.char_code    = i_s_tdata[7:0];
    assign req.cell_address = i_s_tdata[18:8];

    tcw_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res)
    );

    assign res_take = res_valid && (!r_m_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_m_data <= {{(tcw_pkg::OUT_TDATA_W - tcw_pkg::OUT_USED_W){1'b0}},
                         res.did_scroll, res.cursor_column, res.cursor_row,
                         res.cell_value};
        end
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_take) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

### rtl/core/tcw_core.sv
// Screen memory, cursor and the sequencer for puts, reads, clears and scrolls.
`timescale 1ns / 1ps

module tcw_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0] i_cfg_wdata,
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  tcw_pkg::t_request          i_req,
    output logic                       o_res_valid,
    input  logic                       i_res_take,
    output tcw_pkg::t_result           o_res
);

    typedef enum logic [1:0] {S_FILL, S_IDLE, S_READ, S_SCROLL} t_state;

    logic [tcw_pkg::CELL_W-1:0] r_mem [0:tcw_pkg::CELL_COUNT-1];
    logic [tcw_pkg::CELL_W-1:0] r_rd_data;

    t_state                      r_state, n_state;
    logic [tcw_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic [tcw_pkg::CELL_W-1:0]  r_fill_cell, n_fill_cell;
    logic                        r_fill_report, n_fill_report;
    logic [tcw_pkg::ROW_W-1:0]   r_row, n_row;
    logic [tcw_pkg::COL_W-1:0]   r_col, n_col;
    logic [tcw_pkg::ATTR_W-1:0]  r_attr, n_attr;
    logic                        r_res_valid, n_res_valid;
    tcw_pkg::t_result            r_res, n_res;
    logic                        r_rd_ok, n_rd_ok;
    logic                        r_wr_pend, n_wr_pend;
    logic [tcw_pkg::ADDR_W-1:0]  r_wr_addr, n_wr_addr;
    logic                        r_wr_copy, n_wr_copy;

    logic                        w_en;
    logic [tcw_pkg::ADDR_W-1:0]  w_addr;
    logic [tcw_pkg::CELL_W-1:0]  w_data;
    logic [tcw_pkg::ADDR_W-1:0]  rd_addr;
    logic                        accept;
    logic                        finish;
    tcw_pkg::t_result            fin_res;
    logic [tcw_pkg::CELL_W-1:0]  blank;
    logic [tcw_pkg::ADDR_W-1:0]  pos;
    logic                        last_col;
    logic                        last_row;
    logic                        copy_phase;

    assign o_req_ready = (r_state == S_IDLE) && !r_res_valid;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    assign accept   = i_req_valid && o_req_ready;
    assign blank    = {r_attr, tcw_pkg::SPACE_CODE};
    assign pos      = tcw_pkg::ADDR_W'(int'(r_row) * tcw_pkg::SCREEN_COLS + int'(r_col));
    assign last_col = (r_col == tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLS - 1));
    assign last_row = (r_row == tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1));
    assign copy_phase =
        (r_idx < tcw_pkg::IDX_W'(tcw_pkg::CELL_COUNT - tcw_pkg::SCREEN_COLS));

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_fill_cell   = r_fill_cell;
        n_fill_report = r_fill_report;
        n_row         = r_row;
        n_col         = r_col;
        n_attr        = r_attr;
        n_rd_ok       = r_rd_ok;
        n_wr_pend     = r_wr_pend;
        n_wr_addr     = r_wr_addr;
        n_wr_copy     = r_wr_copy;
        w_en          = 1'b0;
        w_addr        = '0;
        w_data        = '0;
        rd_addr       = '0;
        finish        = 1'b0;
        fin_res       = '{did_scroll: 1'b0, cursor_column: r_col,
                          cursor_row: r_row, cell_value: '0};

        if (i_cfg_we) begin
            n_attr = i_cfg_wdata;
        end

        unique case (r_state)
            S_FILL: begin
                w_en   = 1'b1;
                w_addr = r_idx[tcw_pkg::ADDR_W-1:0];
                w_data = r_fill_cell;
                n_idx  = r_idx + 1'b1;
                if (r_idx == tcw_pkg::IDX_W'(tcw_pkg::CELL_COUNT - 1)) begin
                    n_state       = S_IDLE;
                    finish        = r_fill_report;
                    n_fill_report = 1'b0;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req.opcode)
                        tcw_pkg::OP_PUT: begin
                            if (i_req.char_code != tcw_pkg::NEWLINE_CODE) begin
                                w_en   = 1'b1;
                                w_addr = pos;
                                w_data = {r_attr, i_req.char_code};
                                n_col  = r_col + 1'b1;
                            end
                            if (i_req.char_code == tcw_pkg::NEWLINE_CODE || last_col) begin
                                n_col = '0;
                                if (last_row) begin
                                    n_state     = S_SCROLL;
                                    n_idx       = '0;
                                    n_fill_cell = blank;
                                end else begin
                                    n_row = r_row + 1'b1;
                                end
                            end
                            if (!((i_req.char_code == tcw_pkg::NEWLINE_CODE || last_col)
                                  && last_row)) begin
                                finish  = 1'b1;
                                fin_res = '{did_scroll: 1'b0, cursor_column: n_col,
                                            cursor_row: n_row, cell_value: '0};
                            end
                        end
                        tcw_pkg::OP_CLEAR: begin
                            n_state       = S_FILL;
                            n_idx         = '0;
                            n_fill_cell   = blank;
                            n_fill_report = 1'b1;
                        end
                        tcw_pkg::OP_READ: begin
                            rd_addr = tcw_pkg::ADDR_W'(i_req.cell_address);
                            n_rd_ok = (int'(i_req.cell_address) < tcw_pkg::CELL_COUNT);
                            n_state = S_READ;
                        end
                        default: begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                finish  = 1'b1;
                fin_res = '{did_scroll: 1'b0, cursor_column: r_col, cursor_row: r_row,
                            cell_value: r_rd_ok ? r_rd_data : '0};
                n_state = S_IDLE;
            end
            S_SCROLL: begin
                if (copy_phase) begin
                    rd_addr = tcw_pkg::ADDR_W'(r_idx + tcw_pkg::IDX_W'(tcw_pkg::SCREEN_COLS));
                end
                if (r_wr_pend) begin
                    w_en   = 1'b1;
                    w_addr = r_wr_addr;
                    w_data = r_wr_copy ? r_rd_data : r_fill_cell;
                end
                n_wr_pend = (r_idx < tcw_pkg::IDX_W'(tcw_pkg::CELL_COUNT));
                n_wr_addr = r_idx[tcw_pkg::ADDR_W-1:0];
                n_wr_copy = copy_phase;
                n_idx     = r_idx + 1'b1;
                if (r_idx == tcw_pkg::IDX_W'(tcw_pkg::CELL_COUNT)) begin
                    n_state   = S_IDLE;
                    n_wr_pend = 1'b0;
                    finish    = 1'b1;
                    fin_res   = '{did_scroll: 1'b1, cursor_column: r_col,
                                  cursor_row: r_row, cell_value: '0};
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (finish) begin
            n_res_valid = 1'b1;
            n_res       = fin_res;
        end else begin
            n_res_valid = r_res_valid && !i_res_take;
            n_res       = r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_res     <= n_res;
        r_rd_ok   <= n_rd_ok;
        r_wr_addr <= n_wr_addr;
        r_wr_copy <= n_wr_copy;
        if (!i_rst_n) begin
            r_state       <= S_FILL;
            r_idx         <= '0;
            r_fill_cell   <= {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CODE};
            r_fill_report <= 1'b0;
            r_row         <= '0;
            r_col         <= '0;
            r_attr        <= tcw_pkg::RESET_ATTR;
            r_res_valid   <= 1'b0;
            r_wr_pend     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_idx         <= n_idx;
            r_fill_cell   <= n_fill_cell;
            r_fill_report <= n_fill_report;
            r_row         <= n_row;
            r_col         <= n_col;
            r_attr        <= n_attr;
            r_res_valid   <= n_res_valid;
            r_wr_pend     <= n_wr_pend;
        end
    end

endmodule

### rtl/core/tcw_checker.sv
// Port-level checks of the text console writer and their binding.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcw_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [tcw_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam logic [tcw_pkg::ROW_W-1:0] LAST_ROW = tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1);
    localparam logic [tcw_pkg::COL_W-1:0] LAST_COL = tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLS - 1);

    logic [tcw_pkg::CELL_W-1:0] m_cell;
    logic [tcw_pkg::ROW_W-1:0]  m_row;
    logic [tcw_pkg::COL_W-1:0]  m_col;
    logic                       m_scroll;
    logic                       m_stall;
    logic                       m_scroll_ok;

    assign m_cell      = o_m_tdata[15:0];
    assign m_row       = o_m_tdata[20:16];
    assign m_col       = o_m_tdata[27:21];
    assign m_scroll    = o_m_tdata[28];
    assign m_stall     = o_m_tvalid && !i_m_tready;
    assign m_scroll_ok = (m_row == LAST_ROW) && (m_col == '0) && (m_cell == '0);

    `TCW_ASSERT(a_result_held, i_clk, i_rst_n, m_stall |=> o_m_tvalid && $stable(o_m_tdata))
    `TCW_ASSERT(a_cursor_range, i_clk, i_rst_n, o_m_tvalid |-> (m_row <= LAST_ROW) && (m_col <= LAST_COL))
    `TCW_ASSERT(a_scroll_cursor, i_clk, i_rst_n, o_m_tvalid && m_scroll |-> m_scroll_ok)
    `TCW_ASSERT(a_one_at_a_time, i_clk, i_rst_n, i_s_tvalid && o_s_tready |=> !o_s_tready)
    `TCW_ASSERT_ALWAYS(a_busy_after_reset, i_clk, !i_rst_n |=> !o_s_tready && !o_m_tvalid)

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
